// File: src/bbd_pkg.sv
`default_nettype none

package bbd_pkg;

  // Line buffer geometry and field widths.
  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_W       = HEIGHT_W;
  localparam int SAMPLE_W    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_DATA_W  = 13;

  // Result queue in front of the output port.
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Neighborhood, [row][column], row 0 above and column 0 to the left.
  typedef logic [2:0][2:0][SAMPLE_W-1:0] nbhd_t;

  // Position flags of the pixel being interpolated.
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_odd;
    logic y_odd;
    logic e_edge;
    logic s_edge;
    logic last;
  } site_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
    logic    frame_end;
  } rgb_t;

endpackage

`default_nettype wire

// File: src/bilinear_bayer_demosaic.sv
`default_nettype none

// Bilinear demosaic of a BGGR Bayer mosaic, one raw sample per request.
// Input channel: in_valid_i / in_stall_o carry mode_i and sample_i in raster
// order. A request with mode_i low is a raw sample; after the last raw sample
// of a frame, frame_width + 1 flush requests (mode_i high) push out the rest of
// the frame. A flush request that arrives while raw samples are still expected
// is taken and dropped.
// Output channel: out_valid_o / out_stall_i carry red_o, green_o, blue_o and
// frame_end_o, which is high on the bottom-right pixel of the frame.
// Pixel (x, y) comes from the request for (x + 1, y + 1), one line and one
// pixel behind; the last pixel of a line comes from the first request two
// lines down, or from the final flush. Results pass stages 1 and 2 and the
// result queue. One request per clock is taken while in_stall_o is low: the
// single dual-ported line buffer is read on accept, written back next cycle.
// A four-entry result queue decouples the two sides: when the receiver
// stalls, requests keep being accepted until the queue together with the
// results still in the pipeline would fill it, then in_stall_o rises.
// Reset restores a 640 x 480 frame and starts at the top-left pixel; the line
// buffer is not cleared, since no output depends on lines of an older frame.
// The configuration port writes frame_width (index 0) or frame_height
// (index 1) and restarts the frame; write it only while the block is idle.
module bilinear_bayer_demosaic
  import bbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  mode_i,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]        red_o,
  output logic [SAMPLE_W-1:0]        green_o,
  output logic [SAMPLE_W-1:0]        blue_o,
  output logic                       frame_end_o
);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 1);

  function automatic sample_t avg2(sample_t a, sample_t b);
    logic [SAMPLE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SAMPLE_W:1];
  endfunction

  function automatic sample_t avg4(sample_t a, sample_t b, sample_t c, sample_t d);
    logic [SAMPLE_W+1:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return sum[SAMPLE_W+1:2];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration and input position counters.
  // ---------------------------------------------------------------------
  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;

  logic [WIDTH_W-1:0]  cfg_w_raw, cfg_w_clamp, cfg_w_even;
  logic [HEIGHT_W-1:0] cfg_h_even;

  logic                in_fire;
  logic                take;
  logic                phantom_row;
  logic                final_item;
  logic [COL_W-1:0]    col_c;
  logic [WIDTH_W-1:0]  col_inc;
  logic                line_end;
  logic [COL_W-1:0]    width_m1;
  logic [ROW_W-1:0]    height_m1;

  // Stage 1: memory read data arrives, line buffer write-back, window shift.
  logic                s1_mem_q;
  logic                s1_emit_q;
  logic                s1_shift_q;
  logic                s1_last_q;
  logic [COL_W-1:0]    s1_x_q;
  logic [ROW_W-1:0]    s1_y_q;
  logic [COL_W-1:0]    s1_col_q;
  sample_t             s1_pix_q;

  // Stage 2: neighborhood and site flags registered for interpolation.
  logic                s2_valid_q;
  nbhd_t               s2_nb_q;
  site_t               s2_site_q;

  // Result queue.
  rgb_t                fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                fifo_pop;
  logic [FIFO_CNT_W-1:0] occupancy;

  assign cfg_w_raw   = cfg_data_i[WIDTH_W-1:0];
  assign cfg_w_clamp = (cfg_w_raw > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : cfg_w_raw;
  assign cfg_w_even  = cfg_w_clamp & ~WIDTH_W'(1);
  assign cfg_h_even  = cfg_data_i[HEIGHT_W-1:0] & ~HEIGHT_W'(1);

  // Results in the queue or still in flight bound the acceptance of requests.
  assign occupancy  = cnt_q + FIFO_CNT_W'(s1_emit_q) + FIFO_CNT_W'(s2_valid_q);
  assign in_stall_o = (occupancy >= FIFO_CNT_W'(FIFO_DEPTH));
  assign in_fire    = in_valid_i && !in_stall_o;

  assign col_c       = ({1'b0, col_q} >= width_q) ? '0 : col_q;
  assign phantom_row = (row_q >= height_q);
  assign final_item  = (row_q > height_q);
  // Flush requests are dropped until the whole raw frame has arrived.
  assign take        = in_fire && (phantom_row || !mode_i);
  assign col_inc     = {1'b0, col_c} + WIDTH_W'(1);
  assign line_end    = (col_inc >= width_q);
  assign width_m1    = COL_W'(width_q - WIDTH_W'(1));
  assign height_m1   = height_q - ROW_W'(1);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH: begin
          width_d = (cfg_w_even < WIDTH_W'(2)) ? WIDTH_W'(2) : cfg_w_even;
        end
        CFG_FRAME_HEIGHT: begin
          height_d = (cfg_h_even < HEIGHT_W'(2)) ? HEIGHT_W'(2) : cfg_h_even;
        end
      endcase
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (final_item) begin
        col_d = '0;
        row_d = '0;
      end else if (line_end) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(640);
      height_q <= HEIGHT_W'(480);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0 to stage 1: what the accepted request will do.
  // The right end of a line is emitted when the next line starts, from the
  // window as it stood before the shift, with the east column mirrored.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_mem_q   <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_shift_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_mem_q   <= take && !final_item;
      s1_emit_q  <= take && (final_item ||
                             (col_c == '0 && row_q >= ROW_W'(2)) ||
                             (col_c != '0 && row_q != '0));
      s1_shift_q <= final_item || (col_c == '0);
      s1_last_q  <= final_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_col_q <= col_c;
      s1_pix_q <= phantom_row ? '0 : (sample_i & SAMPLE_MASK);
      if (final_item) begin
        s1_x_q <= width_m1;
        s1_y_q <= height_m1;
      end else if (col_c == '0) begin
        s1_x_q <= width_m1;
        s1_y_q <= row_q - ROW_W'(2);
      end else begin
        s1_x_q <= col_c - COL_W'(1);
        s1_y_q <= row_q - ROW_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line buffer: one entry per column holds the samples of the two previous
  // lines, {upper, middle}. Read in the accept cycle, written back in stage 1.
  // A read of the entry being written in the same cycle takes the new data.
  // ---------------------------------------------------------------------
  logic [2*SAMPLE_W-1:0] line_mem_q [MAX_WIDTH];
  logic [2*SAMPLE_W-1:0] mem_rdata_q;
  logic [2*SAMPLE_W-1:0] fwd_data_q;
  logic                  fwd_hit_q;
  logic [2*SAMPLE_W-1:0] mem_rdata;
  logic [2*SAMPLE_W-1:0] mem_wdata;
  logic                  mem_rd_en;
  sample_t               top_s, mid_s;

  assign mem_rd_en = take && !final_item;
  assign mem_rdata = fwd_hit_q ? fwd_data_q : mem_rdata_q;
  assign top_s     = mem_rdata[2*SAMPLE_W-1:SAMPLE_W];
  assign mid_s     = mem_rdata[SAMPLE_W-1:0];
  assign mem_wdata = {mid_s, s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (s1_mem_q) begin
      line_mem_q[s1_col_q] <= mem_wdata;
    end
    if (mem_rd_en) begin
      mem_rdata_q <= line_mem_q[col_c];
      fwd_hit_q   <= s1_mem_q && (s1_col_q == col_c);
      fwd_data_q  <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // 3x3 window and stage 1 to stage 2.
  // ---------------------------------------------------------------------
  nbhd_t              win_q;
  nbhd_t              s1_nb;
  logic [2:0][SAMPLE_W-1:0] new_col;
  site_t              s1_site;

  assign new_col[0] = top_s;
  assign new_col[1] = mid_s;
  assign new_col[2] = s1_pix_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_nb[i][0] = win_q[i][1];
      s1_nb[i][1] = win_q[i][2];
      s1_nb[i][2] = s1_shift_q ? win_q[i][2] : new_col[i];
    end
    s1_site.x_zero = (s1_x_q == '0);
    s1_site.y_zero = (s1_y_q == '0);
    s1_site.x_odd  = s1_x_q[0];
    s1_site.y_odd  = s1_y_q[0];
    s1_site.e_edge = (({1'b0, s1_x_q} + WIDTH_W'(1)) >= width_q);
    s1_site.s_edge = ((s1_y_q + ROW_W'(1)) >= height_q);
    s1_site.last   = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_mem_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
          win_q[i][2] <= new_col[i];
        end
      end
      s2_valid_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit_q) begin
      s2_nb_q   <= s1_nb;
      s2_site_q <= s1_site;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: bilinear interpolation with the edge rules. Neighbors beyond
  // the east or south edge are mirrored from the west or north side.
  // ---------------------------------------------------------------------
  sample_t n_s, s_s, e_s, w_s, nw_s, ne_s, sw_s, se_s, c_s;
  rgb_t    result;

  always_comb begin
    c_s  = s2_nb_q[1][1];
    n_s  = s2_nb_q[0][1];
    s_s  = s2_nb_q[2][1];
    w_s  = s2_nb_q[1][0];
    e_s  = s2_nb_q[1][2];
    nw_s = s2_nb_q[0][0];
    ne_s = s2_nb_q[0][2];
    sw_s = s2_nb_q[2][0];
    se_s = s2_nb_q[2][2];
    if (s2_site_q.e_edge) begin
      e_s  = w_s;
      ne_s = nw_s;
      se_s = sw_s;
    end
    if (s2_site_q.s_edge) begin
      s_s  = n_s;
      sw_s = nw_s;
      se_s = ne_s;
    end

    result.frame_end = s2_site_q.last;
    if (!s2_site_q.x_odd && !s2_site_q.y_odd) begin
      // Blue site.
      result.blue = c_s;
      priority if (s2_site_q.y_zero && s2_site_q.x_zero) begin
        result.green = avg2(e_s, s_s);
      end else if (s2_site_q.y_zero) begin
        result.green = avg2(e_s, w_s);
      end else if (s2_site_q.x_zero) begin
        result.green = avg2(n_s, s_s);
      end else begin
        result.green = avg4(n_s, s_s, e_s, w_s);
      end
      result.red = (s2_site_q.x_zero || s2_site_q.y_zero) ? se_s :
                   avg4(nw_s, ne_s, se_s, sw_s);
    end else if (s2_site_q.x_odd && s2_site_q.y_odd) begin
      // Red site.
      result.red   = c_s;
      result.green = avg4(n_s, s_s, e_s, w_s);
      result.blue  = (s2_site_q.e_edge || s2_site_q.s_edge) ? nw_s :
                     avg4(nw_s, ne_s, se_s, sw_s);
    end else begin
      // Green site; red uses the vertical pair in blue rows.
      result.green = c_s;
      priority if (s2_site_q.e_edge) begin
        result.blue = w_s;
      end else if (s2_site_q.s_edge) begin
        result.blue = n_s;
      end else if (s2_site_q.x_odd) begin
        result.blue = avg2(e_s, w_s);
      end else begin
        result.blue = avg2(n_s, s_s);
      end
      priority if (s2_site_q.x_zero) begin
        result.red = e_s;
      end else if (s2_site_q.y_zero) begin
        result.red = s_s;
      end else if (!s2_site_q.y_odd) begin
        result.red = avg2(n_s, s_s);
      end else begin
        result.red = avg2(e_s, w_s);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result queue and output port.
  // ---------------------------------------------------------------------
  assign out_valid_o = (cnt_q != '0);
  assign fifo_pop    = out_valid_o && !out_stall_i;
  assign red_o       = fifo_q[rd_ptr_q].red;
  assign green_o     = fifo_q[rd_ptr_q].green;
  assign blue_o      = fifo_q[rd_ptr_q].blue;
  assign frame_end_o = fifo_q[rd_ptr_q].frame_end;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      fifo_q[wr_ptr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s2_valid_q) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(s2_valid_q) - FIFO_CNT_W'(fifo_pop);
    end
  end

`ifndef SYNTHESIS
  // Results in flight never outnumber the queue slots reserved for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + {{FIFO_CNT_W{1'b0}}, s1_emit_q} + {{FIFO_CNT_W{1'b0}}, s2_valid_q})
      <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
    else $error("result queue overcommitted");

  // The input column always lies inside the configured line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < width_q)
    else $error("input column beyond frame width");

  // The row counter stops at the final flush row of the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_q} <= ({1'b0, height_q} + (HEIGHT_W+1)'(1)))
    else $error("input row beyond flush row");

  // A frame end result restarts the input position at the top-left pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && final_item && !cfg_we_i) |=> (col_q == '0 && row_q == '0))
    else $error("frame not restarted after final pixel");
`endif

endmodule

`default_nettype wire
